@@ sv/alct_pkg.sv @@
// ----------------------------------------------------------------------------
// alct_pkg
// Shared types and codes for the layered box collision table: transaction
// payloads, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package alct_pkg;

  // fixed field widths of the payload
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned LAYER_BITS = 16;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned SIZE_BITS  = COORD_BITS - 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTREG = 2'd2;

  // input transaction
  typedef struct packed {
    logic        [CMD_W-1:0]      cmd;
    logic        [SLOT_W-1:0]     slot;
    logic        [LAYER_BITS-1:0] layer;
    logic        [LAYER_BITS-1:0] collides_with;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic        [SIZE_BITS-1:0]  box_w;
    logic        [SIZE_BITS-1:0]  box_h;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] result_slot;
    logic              hit;
    logic              last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic walk_clear;
    logic find_step;
    logic rsp_load;
    logic q_read;
    logic q_latch;
    logic scan_en;
    logic flush_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             registered;
    logic             find_end;
    logic             scan_done;
    logic             out_free;
  } dp_status_t;

endpackage

@@ sv/alct_ctrl.sv @@
// ----------------------------------------------------------------------------
// alct_ctrl
// Sequencer for the collision table: decodes each command and steps the
// datapath through free-slot search, query load, slot walk and response.
// ----------------------------------------------------------------------------
module alct_ctrl
  import alct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_FIND   = 8'b0000_0100,
    S_RESP   = 8'b0000_1000,
    S_QREAD  = 8'b0001_0000,
    S_QLATCH = 8'b0010_0000,
    S_SCAN   = 8'b0100_0000,
    S_FLUSH  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // only an idle controller takes a new transaction
  assign in_stall = (state_r != S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.cmd)
          CMD_REGISTER: begin
            cmd.walk_clear = 1'b1;
            state_nxt      = S_FIND;
          end
          CMD_CHECK: begin
            state_nxt = status.registered ? S_QREAD : S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (status.find_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (status.out_free) begin
          cmd.rsp_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_QREAD: begin
        cmd.q_read = 1'b1;
        state_nxt  = S_QLATCH;
      end
      S_QLATCH: begin
        cmd.q_latch = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.flush_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/alct_dp.sv @@
// ----------------------------------------------------------------------------
// alct_dp
// Datapath of the collision table: slot memories, valid bits, high-water
// mark, query registers, the two-stage slot walk and the result register.
// ----------------------------------------------------------------------------
module alct_dp
  import alct_pkg::*;
#(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned HITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic       out_stall,
  output logic       out_valid,
  output out_item_t  out_data
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned HC_W  = $clog2(HITS + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [SIZE_BITS-1:0]  w;
    logic        [SIZE_BITS-1:0]  h;
  } box_t;

  typedef struct packed {
    logic [LAYER_BITS-1:0] layer;
    logic [LAYER_BITS-1:0] mask;
  } masks_t;

  // strict overlap of two boxes; empty boxes never overlap
  function automatic logic boxes_overlap(input box_t a, input box_t b);
    logic signed [COORD_BITS:0] ax, ay, bx, by, ax_end, ay_end, bx_end, by_end;
    ax     = (COORD_BITS+1)'(a.x);
    ay     = (COORD_BITS+1)'(a.y);
    bx     = (COORD_BITS+1)'(b.x);
    by     = (COORD_BITS+1)'(b.y);
    ax_end = ax + $signed({2'b00, a.w});
    ay_end = ay + $signed({2'b00, a.h});
    bx_end = bx + $signed({2'b00, b.w});
    by_end = by + $signed({2'b00, b.h});
    if (a.w == '0 || a.h == '0 || b.w == '0 || b.h == '0) begin
      return 1'b0;
    end
    return (ax < bx_end) && (bx < ax_end) && (ay < by_end) && (by < ay_end);
  endfunction

  // latched command transaction
  in_item_t          item_r;
  logic [IDX_W-1:0]  s_idx;
  logic              in_range;
  logic              registered;

  // table state
  logic [SLOTS-1:0]  valid_r;
  logic [IDX_W:0]    hw_r;
  box_t              box_mem [SLOTS];
  masks_t            mask_mem [SLOTS];
  box_t              box_rd_r;
  masks_t            mask_rd_r;

  // free-slot search
  logic [IDX_W:0]    walk_ptr_r;
  logic [IDX_W-1:0]  walk_idx;
  logic [IDX_W-1:0]  target_r;
  logic              full_r;

  // query and walk pipeline
  box_t                  q_box_r;
  logic [LAYER_BITS-1:0] q_mask_r;
  logic                  cmp_valid_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [HC_W-1:0]       hit_cnt_r;
  logic                  pend_valid_r;
  logic [IDX_W-1:0]      pend_r;
  logic                  limit;
  logic                  cand_hit;
  logic                  hold;
  logic                  scan_issue;
  logic                  push_load;

  // memory access
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              box_we;
  logic              mask_we;
  logic [IDX_W-1:0]  wr_addr;

  // result register
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         rsp;
  logic              out_free;
  logic              out_load;
  out_item_t         out_load_data;

  // addressed slot
  assign s_idx      = IDX_W'(item_r.slot);
  assign in_range   = 32'(item_r.slot) < 32'(SLOTS);
  assign registered = in_range && valid_r[s_idx];
  assign walk_idx   = walk_ptr_r[IDX_W-1:0];

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status toward the controller
  assign limit            = (hit_cnt_r == HC_W'(HITS));
  assign status.cmd        = item_r.cmd;
  assign status.registered = registered;
  assign status.find_end   = !valid_r[walk_idx] || (walk_idx == IDX_W'(SLOTS - 1));
  assign status.scan_done  = limit || (!cmp_valid_r && (walk_ptr_r == hw_r));
  assign status.out_free   = out_free;

  // compare stage of the walk
  assign cand_hit = cmd.scan_en && cmp_valid_r && !limit && (cmp_idx_r != s_idx) &&
                    valid_r[cmp_idx_r] && ((q_mask_r & mask_rd_r.layer) != '0) &&
                    boxes_overlap(q_box_r, box_rd_r);
  assign hold       = cand_hit && pend_valid_r && !out_free;
  assign push_load  = cand_hit && pend_valid_r && out_free;
  assign scan_issue = cmd.scan_en && !hold && !limit && (walk_ptr_r < hw_r);

  // memory ports
  assign rd_en   = cmd.q_read || scan_issue;
  assign rd_addr = cmd.q_read ? s_idx : walk_idx;
  assign mask_we = cmd.rsp_load && (item_r.cmd == CMD_REGISTER) && !full_r;
  assign box_we  = mask_we || (cmd.rsp_load && (item_r.cmd == CMD_UPDATE) && registered);
  assign wr_addr = (item_r.cmd == CMD_REGISTER) ? target_r : s_idx;

  // single response for all but hit results
  always_comb begin
    rsp        = '0;
    rsp.status = STAT_OK;
    rsp.last   = 1'b1;
    case (item_r.cmd)
      CMD_REGISTER: begin
        if (full_r) begin
          rsp.status = STAT_FULL;
        end else begin
          rsp.result_slot = SLOT_W'(target_r);
        end
      end
      CMD_UPDATE, CMD_REMOVE: begin
        if (registered) begin
          rsp.result_slot = SLOT_W'(s_idx);
        end else begin
          rsp.status = STAT_NOTREG;
        end
      end
      CMD_CHECK: begin
        rsp.status = STAT_NOTREG;
      end
      default: begin
        rsp.status = STAT_OK;
      end
    endcase
  end

  // result register source select
  always_comb begin
    out_load      = cmd.rsp_load || push_load || cmd.flush_load;
    out_load_data = rsp;
    if (push_load) begin
      out_load_data.status      = STAT_OK;
      out_load_data.result_slot = SLOT_W'(pend_r);
      out_load_data.hit         = 1'b1;
      out_load_data.last        = 1'b0;
    end else if (cmd.flush_load) begin
      out_load_data.status      = STAT_OK;
      out_load_data.result_slot = pend_valid_r ? SLOT_W'(pend_r) : '0;
      out_load_data.hit         = pend_valid_r;
      out_load_data.last        = 1'b1;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (box_we) begin
      box_mem[wr_addr] <= '{x: item_r.box_x, y: item_r.box_y,
                            w: item_r.box_w, h: item_r.box_h};
    end
    if (mask_we) begin
      mask_mem[wr_addr] <= '{layer: item_r.layer, mask: item_r.collides_with};
    end
    if (rd_en) begin
      box_rd_r  <= box_mem[rd_addr];
      mask_rd_r <= mask_mem[rd_addr];
    end
  end

  // valid bits and high-water mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hw_r    <= '0;
    end else if (cmd.rsp_load) begin
      case (item_r.cmd)
        CMD_REGISTER: begin
          if (!full_r) begin
            valid_r[target_r] <= 1'b1;
            if (({1'b0, target_r} + 1'b1) > hw_r) begin
              hw_r <= {1'b0, target_r} + 1'b1;
            end
          end
        end
        CMD_REMOVE: begin
          if (registered) begin
            valid_r[s_idx] <= 1'b0;
          end
        end
        CMD_CLEAR: begin
          valid_r <= '0;
          hw_r    <= '0;
        end
        default: begin
          hw_r <= hw_r;
        end
      endcase
    end
  end

  // free-slot search result
  always_ff @(posedge clk) begin
    if (cmd.find_step) begin
      if (!valid_r[walk_idx]) begin
        target_r <= walk_idx;
        full_r   <= 1'b0;
      end else if (walk_idx == IDX_W'(SLOTS - 1)) begin
        full_r <= 1'b1;
      end
    end
  end

  // query registers
  always_ff @(posedge clk) begin
    if (cmd.q_latch) begin
      q_box_r  <= box_rd_r;
      q_mask_r <= mask_rd_r.mask;
    end
    if (cand_hit && !hold) begin
      pend_r <= cmp_idx_r;
    end
    if (scan_issue) begin
      cmp_idx_r <= walk_idx;
    end
  end

  // walk pointer, compare stage and hit bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_ptr_r   <= '0;
      cmp_valid_r  <= 1'b0;
      hit_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.walk_clear || cmd.q_latch) begin
      walk_ptr_r   <= '0;
      cmp_valid_r  <= 1'b0;
      hit_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.find_step) begin
      walk_ptr_r <= walk_ptr_r + 1'b1;
    end else if (cmd.scan_en && !hold) begin
      cmp_valid_r <= scan_issue;
      if (scan_issue) begin
        walk_ptr_r <= walk_ptr_r + 1'b1;
      end
      if (cand_hit) begin
        pend_valid_r <= 1'b1;
        hit_cnt_r    <= hit_cnt_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register loaded while a stalled result waits");

  // the hit budget is never exceeded
  a_hit_budget: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= HC_W'(HITS))
    else $error("hit count above limit");

  // a stalled walk keeps its compare stage and pointer
  a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    hold |=> $stable(walk_ptr_r) && $stable(cmp_idx_r) && $stable(box_rd_r))
    else $error("walk advanced while a hit was held");

endmodule

@@ sv/aabb_layer_collision_table.sv @@
// ----------------------------------------------------------------------------
// aabb_layer_collision_table
// Table of layered axis-aligned boxes with register, update, remove, clear
// and collision check commands.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ channel (valid/stall); results leave on
// the out_ channel. Every command yields one or more result transactions and
// the final one carries last. A check yields one result per colliding slot,
// at most HITS, or a single empty result.
// One command is in work at a time; in_stall stays high from acceptance until
// its final result is loaded into the output register, so the next command
// is taken while that result still waits to be read.
// Flow: update, remove, clear and unknown codes go through decode to the
// result; register adds the free-slot search, one slot per cycle through
// the valid bits; check walks the slots below the high-water mark, reading
// one slot per cycle while no held hit stalls the walk, from the slot memory
// through a two-stage read and compare pipeline.
// Reset clears all valid bits, the high-water mark and the output valid bit;
// slot contents are only used for valid slots. A stalled receiver holds the
// output register, and a check walk pauses on its next hit until it drains.
// ----------------------------------------------------------------------------
module aabb_layer_collision_table
  import alct_pkg::*;
#(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned HITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // command sequencer
  alct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // table and walk datapath
  alct_dp #(
    .SLOTS (SLOTS),
    .HITS  (HITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
